// ===== sv/pfd_pkg.sv =====
// Shared types and constants for the PCM frame deframer.
`default_nettype none
package pfd_pkg;

   // Header geometry and byte counter
   localparam int HEADER_BYTES = 64;
   localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
   localparam int POS_W        = 12;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Header field values that a good header carries
   localparam logic [31:0] MAGIC_BPV1   = 32'h4250_5631;
   localparam logic [7:0]  VERSION_ONE  = 8'd1;
   localparam logic [7:0]  DIR_DOWN     = 8'd2;
   localparam logic [15:0] HDR_LEN      = 16'd64;
   localparam logic [7:0]  FORMAT_ONE   = 8'd1;
   localparam logic [31:0] SAMPLE_RATE  = 32'd24000;
   localparam logic [15:0] KNOWN_FLAGS  = 16'h0007;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 8;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEVICE_ID_HIGH = 8'd0,
      CSR_DEVICE_ID_LOW  = 8'd1
   } csr_index_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_HEADER  = 2'd1,
      STATUS_FRAMING = 2'd2
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [15:0] frame_flags;
      logic [31:0] sequence_number;
      logic [63:0] stamp_us;
      logic [31:0] epoch_id;
      logic [31:0] sess_id;
      logic [31:0] turn_id;
      logic [31:0] strm_id;
      logic [31:0] payload_length;
      status_type  frame_status;
      logic        final_flag;
   } result_type;

   // Results produced by one accepted byte: count and the two slots
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage
`default_nettype wire

// ===== sv/pcm_frame_deframer.sv =====
// Top level of the PCM frame deframer.
//
// Takes one message byte per cycle. The 64-byte big-endian header is stored
// and checked as it passes; each following payload byte (up to
// MAX_PAYLOAD_BYTES) is handed on as a payload result, and the final byte of
// the message adds a summary result with the header fields and a status
// (0 ok, 1 bad or short header, 2 framing error; discard the payload unless
// 0). Results of each accepted byte are registered into a four-entry result
// queue that delivers one result per cycle while rsp_ready is high. The final
// payload byte yields two results, so req_ready is low while fewer than two
// queue entries are free; with rsp_ready held high this never happens and
// bytes flow back to back. The user must write the device UUID registers on
// the csr_ port (index 0 high half, 1 low half) only while no message is in
// progress; the block does not enforce it. Writes are taken every cycle.
`default_nettype none
module pcm_frame_deframer #(
   parameter int MAX_PAYLOAD_BYTES = 960
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_last_byte,

   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_result_kind,
   output logic [7:0]        rsp_payload_byte,
   output logic [15:0]       rsp_frame_flags,
   output logic [31:0]       rsp_sequence_number,
   output logic [63:0]       rsp_stamp_us,
   output logic [31:0]       rsp_epoch_id,
   output logic [31:0]       rsp_sess_id,
   output logic [31:0]       rsp_turn_id,
   output logic [31:0]       rsp_strm_id,
   output logic [31:0]       rsp_payload_length,
   output logic [1:0]        rsp_frame_status,
   output logic              rsp_final_flag,

   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                   csr_data
);
   import pfd_pkg::*;

   logic [63:0] dev_hi_ff, dev_lo_ff;
   logic        accept;
   logic        room;
   push_type    push;
   result_type  head;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_hi_ff <= '0;
         dev_lo_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ID_HIGH: dev_hi_ff <= csr_data;
            CSR_DEVICE_ID_LOW:  dev_lo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   pfd_parser #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .device_id_high (dev_hi_ff),
      .device_id_low  (dev_lo_ff),
      .push           (push)
   );

   pfd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .room      (room)
   );

   // Result fields
   assign rsp_result_kind     = head.kind;
   assign rsp_payload_byte    = head.payload_byte;
   assign rsp_frame_flags     = head.frame_flags;
   assign rsp_sequence_number = head.sequence_number;
   assign rsp_stamp_us        = head.stamp_us;
   assign rsp_epoch_id        = head.epoch_id;
   assign rsp_sess_id         = head.sess_id;
   assign rsp_turn_id         = head.turn_id;
   assign rsp_strm_id         = head.strm_id;
   assign rsp_payload_length  = head.payload_length;
   assign rsp_frame_status    = head.frame_status;
   assign rsp_final_flag      = head.final_flag;

endmodule
`default_nettype wire

// ===== sv/pfd_parser.sv =====
// Byte position tracking, header store, header checks and result building.
`default_nettype none
module pfd_parser #(
   parameter int MAX_PAYLOAD_BYTES = 960
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              last_byte,
   input  wire logic [63:0]       device_id_high,
   input  wire logic [63:0]       device_id_low,
   output pfd_pkg::push_type      push
);
   import pfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic [7:0]       hdr_ff [HEADER_BYTES];
   logic [7:0]       hdr_cur [HEADER_BYTES];

   logic             in_header;
   logic             basic_ok, rate_uuid_ok;
   logic [15:0]      flags;
   logic [31:0]      seq, len;
   logic             pass_payload, bad_framing;
   result_type       pay_res, sum_res;

   // Header view including the byte arriving now
   always_comb begin
      hdr_cur = hdr_ff;
      if (in_header) begin
         hdr_cur[pos_ff[HDR_IDX_W-1:0]] = data_byte;
      end
   end

   assign in_header = (pos_ff < POS_W'(HEADER_BYTES));

   // Header checks
   assign basic_ok = ({hdr_cur[0], hdr_cur[1], hdr_cur[2], hdr_cur[3]} == MAGIC_BPV1)
                     && (hdr_cur[4] == VERSION_ONE) && (hdr_cur[5] == DIR_DOWN)
                     && ({hdr_cur[8], hdr_cur[9]} == HDR_LEN)
                     && (hdr_cur[10] == FORMAT_ONE) && (hdr_cur[11] == FORMAT_ONE);
   assign rate_uuid_ok =
      ({hdr_cur[12], hdr_cur[13], hdr_cur[14], hdr_cur[15]} == SAMPLE_RATE)
      && ({hdr_cur[36], hdr_cur[37], hdr_cur[38], hdr_cur[39],
           hdr_cur[40], hdr_cur[41], hdr_cur[42], hdr_cur[43]} == device_id_high)
      && ({hdr_cur[44], hdr_cur[45], hdr_cur[46], hdr_cur[47],
           hdr_cur[48], hdr_cur[49], hdr_cur[50], hdr_cur[51]} == device_id_low);

   assign flags = {hdr_cur[6], hdr_cur[7]};
   assign len   = {hdr_cur[16], hdr_cur[17], hdr_cur[18], hdr_cur[19]};
   assign seq   = {hdr_cur[20], hdr_cur[21], hdr_cur[22], hdr_cur[23]};

   // Position counter saturates; end of message restarts it
   always_comb begin
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
   end

   // Payload pass window
   assign pass_payload = !in_header && hdr_ok_ff
      && ((32'(pos_ff) - 32'(HEADER_BYTES)) < 32'(MAX_PAYLOAD_BYTES));

   assign bad_framing = (len == 32'd0) || (len > 32'(MAX_PAYLOAD_BYTES)) || len[0]
      || (33'(pos_in) != (33'(len) + 33'(HEADER_BYTES)))
      || ((flags & ~KNOWN_FLAGS) != 16'd0)
      || !rate_uuid_ok
      || (seq == 32'hFFFF_FFFF)
      || ((seq == 32'd0) != flags[0]);

   // Result builders
   always_comb begin
      pay_res              = '0;
      pay_res.kind         = KIND_PAYLOAD;
      pay_res.payload_byte = data_byte;
      pay_res.frame_status = STATUS_OK;

      sum_res            = '0;
      sum_res.kind       = KIND_SUMMARY;
      sum_res.final_flag = 1'b1;
      if ((pos_in < POS_W'(HEADER_BYTES)) || !basic_ok) begin
         sum_res.frame_status = STATUS_HEADER;
      end else begin
         sum_res.frame_flags     = flags;
         sum_res.sequence_number = seq;
         sum_res.stamp_us        = {hdr_cur[24], hdr_cur[25], hdr_cur[26], hdr_cur[27],
                                    hdr_cur[28], hdr_cur[29], hdr_cur[30], hdr_cur[31]};
         sum_res.epoch_id        = {hdr_cur[32], hdr_cur[33], hdr_cur[34], hdr_cur[35]};
         sum_res.sess_id         = {hdr_cur[52], hdr_cur[53], hdr_cur[54], hdr_cur[55]};
         sum_res.turn_id         = {hdr_cur[56], hdr_cur[57], hdr_cur[58], hdr_cur[59]};
         sum_res.strm_id         = {hdr_cur[60], hdr_cur[61], hdr_cur[62], hdr_cur[63]};
         sum_res.payload_length  = len;
         sum_res.frame_status    = bad_framing ? STATUS_FRAMING : STATUS_OK;
      end
   end

   // Pack results for the queue: payload first, summary behind it
   always_comb begin
      push.count  = 2'd0;
      push.first  = pay_res;
      push.second = sum_res;
      if (accept) begin
         priority if (pass_payload && last_byte) begin
            push.count = 2'd2;
         end else if (pass_payload) begin
            push.count = 2'd1;
         end else if (last_byte) begin
            push.count = 2'd1;
            push.first = sum_res;
         end else begin
            // header byte or dropped payload byte: nothing to queue
            push.count = 2'd0;
         end
      end
   end

   // Header ok flag
   always_comb begin
      hdr_ok_in = hdr_ok_ff;
      if (pos_ff == POS_W'(HEADER_BYTES - 1)) begin
         hdr_ok_in = basic_ok && rate_uuid_ok;
      end
      if (last_byte) begin
         hdr_ok_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hdr_ok_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= last_byte ? '0 : pos_in;
         hdr_ok_ff <= hdr_ok_in;
      end
   end

   // Header byte store
   always_ff @(posedge clock) begin
      if (accept && in_header) begin
         hdr_ff[pos_ff[HDR_IDX_W-1:0]] <= data_byte;
      end
   end

   // Two results only leave for the final byte after a checked header
   a_payload_needs_header: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (hdr_ok_ff && last_byte))
      else $error("two results without a checked header and final byte");
   // Position restarts after the final byte
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (pos_ff == '0) && !hdr_ok_ff)
      else $error("position not cleared after final byte");
   // Header flag is only raised at the last header byte
   a_hdr_ok_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(hdr_ok_ff) |-> ($past(pos_ff) == POS_W'(HEADER_BYTES - 1)))
      else $error("header flag raised outside the last header byte");

endmodule
`default_nettype wire

// ===== sv/pfd_out_queue.sv =====
// Result queue: takes up to two results a cycle, delivers one while pop is high.
`default_nettype none
module pfd_out_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pfd_pkg::push_type  push,
   input  wire logic               pop,
   output pfd_pkg::result_type     head,
   output logic                    not_empty,
   output logic                    room
);
   import pfd_pkg::*;

   result_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign do_pop    = pop && (cnt_ff != '0);
   assign not_empty = (cnt_ff != '0);
   assign room      = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      cnt_in    = cnt_ff + QCNT_W'(push.count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("push into queue without room");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && (push.count == 2'd0)) |=> (cnt_ff == $past(cnt_ff) - QCNT_W'(1)))
      else $error("pop did not drain an entry");

endmodule
`default_nettype wire
